// ===== rtl/smpt_pkg.sv =====
// ----------------------------------------------------------------------------
// smpt_pkg
// Shared types and codes for the scaled matrix product block.
// ----------------------------------------------------------------------------
package smpt_pkg;

  // request codes carried by an input item
  typedef logic [1:0] req_t;
  localparam req_t REQ_WR_X  = 2'd0;
  localparam req_t REQ_WR_Y  = 2'd1;
  localparam req_t REQ_START = 2'd2;
  localparam req_t REQ_NOP   = 2'd3;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_X_ROWS  = 3'd0;
  localparam cfg_idx_t CFG_X_COLS  = 3'd1;
  localparam cfg_idx_t CFG_Y_ROWS  = 3'd2;
  localparam cfg_idx_t CFG_Y_COLS  = 3'd3;
  localparam cfg_idx_t CFG_X_TRANS = 3'd4;
  localparam cfg_idx_t CFG_Y_TRANS = 3'd5;
  localparam cfg_idx_t CFG_ALPHA   = 3'd6;
  localparam cfg_idx_t CFG_NONE    = 3'd7;

  // fixed widths of the fields
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 67;
  localparam int MUL_W  = 65;
  localparam int SCL_W  = 99;

endpackage

// ===== rtl/smpt_ram.sv =====
// ----------------------------------------------------------------------------
// smpt_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module smpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scaled_matrix_product_transpose.sv =====
// ----------------------------------------------------------------------------
// scaled_matrix_product_transpose
// Stores X and Y in two RAMs and streams alpha * op(X) * op(Y) row-major.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in_     | in_valid / in_ready   | req_type, row_index, col_index, element_value
//  out_    | out_valid / out_ready | out_row, out_col, result_value, flags
//  cfg_    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// element writes are accepted only while idle. a start item keeps the block
// busy; per result element (K = inner dimension): one RAM read pair per k,
// a registered 32x32 multiply, the accumulate, then limb multiplies by alpha
// on one multiplier. reset is synchronous and clears control and sets the
// configuration registers to defaults; stores are undefined until written.
// a stalled output holds the walk until the output register frees.
// ----------------------------------------------------------------------------
module scaled_matrix_product_transpose
  import smpt_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_saturated,
  output logic                     out_dim_error,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int WAW   = 2 * IDX_W;

  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_FIN, ST_OUT, ST_ERR} state_t;

  state_t state_r;

  // configuration registers
  logic [DIM_W-1:0]         x_rows_r, x_cols_r, y_rows_r, y_cols_r;
  logic                     x_trans_r, y_trans_r;
  logic signed [DATA_W-1:0] alpha_r;

  // walk counters and pipeline
  logic [CW-1:0]            i_r, j_r, k_r;
  logic                     issue_r;
  logic                     rd_v_r, rd_last_r;
  logic                     prod_v_r, prod_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [1:0]               fs_r;
  logic signed [MUL_W-1:0]  mul_r;
  logic signed [SCL_W-1:0]  p_r;

  // output register
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_sat_r, out_err_r, out_last_r;

  // clamp a dimension register into 1..MAX_DIM
  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) r = DW'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DW'(MAX_DIM);
    else r = DW'(d);
    return r;
  endfunction

  logic [DW-1:0] xr, xc, yr, yc, m_dim, n_dim, kx_dim, ky_dim;
  always_comb begin
    xr     = clamp_dim(x_rows_r);
    xc     = clamp_dim(x_cols_r);
    yr     = clamp_dim(y_rows_r);
    yc     = clamp_dim(y_cols_r);
    m_dim  = x_trans_r ? xc : xr;
    kx_dim = x_trans_r ? xr : xc;
    ky_dim = y_trans_r ? yc : yr;
    n_dim  = y_trans_r ? yr : yc;
  end

  // input side: writes and start only while idle
  logic in_acc, wr_ok, x_we, y_we, start;
  logic [WAW-1:0] waddr_full;
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    in_acc     = in_valid && in_ready;
    wr_ok      = ({1'b0, in_row_index} < (IDX_W+1)'(MAX_DIM)) &&
                 ({1'b0, in_col_index} < (IDX_W+1)'(MAX_DIM));
    x_we       = in_acc && (in_req_type == REQ_WR_X) && wr_ok;
    y_we       = in_acc && (in_req_type == REQ_WR_Y) && wr_ok;
    start      = in_acc && (in_req_type == REQ_START);
    waddr_full = WAW'(in_row_index) * WAW'(MAX_DIM) + WAW'(in_col_index);
  end

  // read addresses for the current k
  logic [AW-1:0] x_raddr, y_raddr;
  logic          k_last;
  always_comb begin
    x_raddr = x_trans_r ? (AW'(k_r) * AW'(MAX_DIM) + AW'(i_r))
                        : (AW'(i_r) * AW'(MAX_DIM) + AW'(k_r));
    y_raddr = y_trans_r ? (AW'(j_r) * AW'(MAX_DIM) + AW'(k_r))
                        : (AW'(k_r) * AW'(MAX_DIM) + AW'(j_r));
    k_last  = (DW'(k_r) == kx_dim - DW'(1));
  end

  logic [DATA_W-1:0] x_rdata, y_rdata;

  smpt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (AW'(waddr_full)),
    .wdata (in_element_value),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  smpt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (AW'(waddr_full)),
    .wdata (in_element_value),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  // limb of the accumulator for the alpha multiply
  logic signed [DATA_W:0] limb;
  always_comb begin
    case (fs_r)
      2'd0:    limb = $signed({1'b0, acc_r[DATA_W-1:0]});
      2'd1:    limb = $signed({1'b0, acc_r[2*DATA_W-1:DATA_W]});
      default: limb = (DATA_W+1)'($signed(acc_r[ACC_W-1:2*DATA_W]));
    endcase
  end

  // floor to Q16.16 and saturate
  logic signed [SCL_W-DATA_W-1:0] q;
  logic                           q_sat;
  logic signed [DATA_W-1:0]       q_val;
  always_comb begin
    q     = p_r[SCL_W-1:DATA_W];
    q_sat = !((&q[SCL_W-DATA_W-1:DATA_W-1]) || ~|q[SCL_W-DATA_W-1:DATA_W-1]);
    if (q_sat) q_val = q[SCL_W-DATA_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else q_val = q[DATA_W-1:0];
  end

  logic out_free, elem_last;
  always_comb begin
    out_free  = !out_valid_r || out_ready;
    elem_last = (DW'(i_r) == m_dim - DW'(1)) && (DW'(j_r) == n_dim - DW'(1));
  end

  // config port is always ready
  assign cfg_ready = 1'b1;

  // state machine, pipeline and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x_rows_r    <= DIM_W'(1);
      x_cols_r    <= DIM_W'(1);
      y_rows_r    <= DIM_W'(1);
      y_cols_r    <= DIM_W'(1);
      x_trans_r   <= 1'b0;
      y_trans_r   <= 1'b0;
      alpha_r     <= 32'sd65536;
      issue_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      fs_r        <= '0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_X_ROWS:  x_rows_r  <= cfg_data[DIM_W-1:0];
          CFG_X_COLS:  x_cols_r  <= cfg_data[DIM_W-1:0];
          CFG_Y_ROWS:  y_rows_r  <= cfg_data[DIM_W-1:0];
          CFG_Y_COLS:  y_cols_r  <= cfg_data[DIM_W-1:0];
          CFG_X_TRANS: x_trans_r <= cfg_data[0];
          CFG_Y_TRANS: y_trans_r <= cfg_data[0];
          CFG_ALPHA:   alpha_r   <= cfg_data;
          default:     ;
        endcase
      end

      if (out_ready) out_valid_r <= 1'b0;

      // read and multiply stages
      rd_v_r      <= issue_r;
      rd_last_r   <= k_last;
      prod_v_r    <= rd_v_r;
      prod_last_r <= rd_last_r;
      prod_r      <= $signed(x_rdata) * $signed(y_rdata);
      if (prod_v_r) acc_r <= acc_r + ACC_W'(prod_r);

      if (issue_r) begin
        k_r <= k_r + CW'(1);
        if (k_last) issue_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            i_r <= '0;
            j_r <= '0;
            if (kx_dim != ky_dim) begin
              state_r <= ST_ERR;
            end else begin
              state_r <= ST_RUN;
              issue_r <= 1'b1;
              k_r     <= '0;
              acc_r   <= '0;
            end
          end
        end
        ST_RUN: begin
          if (prod_v_r && prod_last_r) begin
            state_r <= ST_FIN;
            fs_r    <= '0;
          end
        end
        ST_FIN: begin
          // limb multiply, then shifted add of the previous limb
          mul_r <= limb * alpha_r;
          case (fs_r)
            2'd0:    p_r <= '0;
            2'd1:    p_r <= p_r + SCL_W'(mul_r);
            2'd2:    p_r <= p_r + (SCL_W'(mul_r) <<< DATA_W);
            default: p_r <= p_r + (SCL_W'(mul_r) <<< (2 * DATA_W));
          endcase
          fs_r <= fs_r + 2'd1;
          if (fs_r == 2'd3) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= IDX_W'(i_r);
            out_col_r   <= IDX_W'(j_r);
            out_value_r <= q_val;
            out_sat_r   <= q_sat;
            out_err_r   <= 1'b0;
            out_last_r  <= elem_last;
            if (elem_last) begin
              state_r <= ST_IDLE;
            end else begin
              if (DW'(j_r) == n_dim - DW'(1)) begin
                j_r <= '0;
                i_r <= i_r + CW'(1);
              end else begin
                j_r <= j_r + CW'(1);
              end
              state_r <= ST_RUN;
              issue_r <= 1'b1;
              k_r     <= '0;
              acc_r   <= '0;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= '0;
            out_col_r   <= '0;
            out_value_r <= '0;
            out_sat_r   <= 1'b0;
            out_err_r   <= 1'b1;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_result_value = out_value_r;
  assign out_saturated    = out_sat_r;
  assign out_dim_error    = out_err_r;
  assign out_last         = out_last_r;

  // the last product of an element only lands during the walk
  a_prod_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r && prod_last_r |-> state_r == ST_RUN)
    else $error("last product outside walk");

  // the pipeline is drained while alpha is applied
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> !prod_v_r && !rd_v_r && !issue_r)
    else $error("pipeline busy during scaling");

  // an error item is always the last one of its run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r)
    else $error("error item not marked last");

  // a clipped value sits at one of the rails
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |->
      (out_value_r == 32'sh7fff_ffff || out_value_r == 32'sh8000_0000))
    else $error("saturated value off the rails");

endmodule

// ===== tb/smpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpt_checker
// Watches the configuration, input and result channels of the scaled matrix
// product block, keeps its own copy of the stores and registers, works out
// alpha * op(X) * op(Y) for every start item and compares each result item
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module smpt_checker
  import smpt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic signed [DATA_W-1:0] in_element_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [IDX_W-1:0]         out_row,
  input  logic [IDX_W-1:0]         out_col,
  input  logic signed [DATA_W-1:0] out_result_value,
  input  logic                     out_saturated,
  input  logic                     out_dim_error,
  input  logic                     out_last,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output int                       fail_count,
  output int                       pending
);

  localparam int DIM = 8;

  typedef struct {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              sat;
    logic              derr;
    logic              last;
  } elem_t;

  // shadow of the stores and registers
  logic [DATA_W-1:0] x_mem [DIM*DIM];
  logic [DATA_W-1:0] y_mem [DIM*DIM];
  logic [DIM_W-1:0]  xr_reg, xc_reg, yr_reg, yc_reg;
  logic              xt_reg, yt_reg;
  logic [DATA_W-1:0] alpha_reg;

  elem_t product_q[$];

  initial fail_count = 0;
  assign pending = product_q.size();

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  // expected result items of one start item
  task automatic predict_product();
    int unsigned xr, xc, yr, yc, m, n, kx, ky, xa, ya;
    logic signed [DATA_W-1:0] xv, yv, av;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SCL_W-1:0]  scl, q;
    elem_t e;
    xr = clamp_dim(xr_reg); xc = clamp_dim(xc_reg);
    yr = clamp_dim(yr_reg); yc = clamp_dim(yc_reg);
    m  = xt_reg ? xc : xr;
    kx = xt_reg ? xr : xc;
    ky = yt_reg ? yc : yr;
    n  = yt_reg ? yr : yc;
    if (kx != ky) begin
      e = '{row: '0, col: '0, value: '0, sat: 1'b0, derr: 1'b1, last: 1'b1};
      product_q.push_back(e);
      return;
    end
    av = alpha_reg;
    for (int unsigned i = 0; i < m; i++) begin
      for (int unsigned j = 0; j < n; j++) begin
        acc = '0;
        for (int unsigned k = 0; k < kx; k++) begin
          xa = xt_reg ? (k * DIM + i) : (i * DIM + k);
          ya = yt_reg ? (j * DIM + k) : (k * DIM + j);
          xv = x_mem[xa];
          yv = y_mem[ya];
          prod = xv * yv;
          acc = acc + prod;
        end
        scl = acc * av;
        // dropping the low 32 bits rounds toward minus infinity
        q = scl >>> 32;
        e.row  = i[IDX_W-1:0];
        e.col  = j[IDX_W-1:0];
        e.derr = 1'b0;
        e.last = (i + 1 == m) && (j + 1 == n);
        if (q > 99'sd2147483647) begin
          e.value = 32'h7FFF_FFFF;
          e.sat = 1'b1;
        end else if (q < -99'sd2147483648) begin
          e.value = 32'h8000_0000;
          e.sat = 1'b1;
        end else begin
          e.value = q[DATA_W-1:0];
          e.sat = 1'b0;
        end
        product_q.push_back(e);
      end
    end
  endtask

  task automatic report(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    fail_count++;
    $display("%0t: %s mismatch: expected %h actual %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      xr_reg <= 4'd1; xc_reg <= 4'd1; yr_reg <= 4'd1; yc_reg <= 4'd1;
      xt_reg <= 1'b0; yt_reg <= 1'b0;
      alpha_reg <= 32'h0001_0000;
      product_q.delete();
    end else begin
      // result items against the oldest expectation
      if (out_valid && out_ready) begin
        if (product_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item: expected none actual row %0d col %0d value %h",
                   $realtime, out_row, out_col, out_result_value);
        end else begin
          elem_t e;
          e = product_q.pop_front();
          if (out_row !== e.row) report("out_row", e.row, out_row);
          if (out_col !== e.col) report("out_col", e.col, out_col);
          if (out_result_value !== e.value) report("result_value", e.value, out_result_value);
          if (out_saturated !== e.sat) report("saturated", e.sat, out_saturated);
          if (out_dim_error !== e.derr) report("dim_error", e.derr, out_dim_error);
          if (out_last !== e.last) report("last", e.last, out_last);
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_X_ROWS:  xr_reg <= cfg_data[DIM_W-1:0];
          CFG_X_COLS:  xc_reg <= cfg_data[DIM_W-1:0];
          CFG_Y_ROWS:  yr_reg <= cfg_data[DIM_W-1:0];
          CFG_Y_COLS:  yc_reg <= cfg_data[DIM_W-1:0];
          CFG_X_TRANS: xt_reg <= cfg_data[0];
          CFG_Y_TRANS: yt_reg <= cfg_data[0];
          CFG_ALPHA:   alpha_reg <= cfg_data;
          default: ;
        endcase
      end
      // input items
      if (in_valid && in_ready) begin
        case (in_req_type)
          REQ_WR_X:  x_mem[{in_row_index, in_col_index}] = in_element_value;
          REQ_WR_Y:  y_mem[{in_row_index, in_col_index}] = in_element_value;
          REQ_START: predict_product();
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/scaled_matrix_product_transpose_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_matrix_product_transpose_tb
// Fills both stores, runs directed register settings and start items, then
// random phases of element writes and starts under random stalls on both
// channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module scaled_matrix_product_transpose_tb;
  import smpt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;
  localparam int LONG_HOLD = 400;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_req_type = REQ_WR_X;
  logic [IDX_W-1:0]         in_row_index = '0;
  logic [IDX_W-1:0]         in_col_index = '0;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_result_value;
  logic                     out_saturated;
  logic                     out_dim_error;
  logic                     out_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [2:0]               cfg_index = CFG_X_ROWS;
  logic [DATA_W-1:0]        cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  bit hold_req = 1'b0;
  bit gaps_on = 1'b1;

  scaled_matrix_product_transpose u_dut (.*);

  smpt_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random ready, one long hold-off on request
  initial begin
    int r, len;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        out_ready <= (r < 65);
        if (r < 90) len = $urandom_range(1, 4);
        else len = $urandom_range(10, 40);
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5: return 32'hFFFF_FFFF;
      6, 7: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 4'd0;
      1: return 4'd15;
      2: return DIM_W'($urandom_range(9, 14));
      3, 4: return 4'd8;
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // one input item, with an optional gap in front
  task automatic send_item(logic [1:0] req, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic [DATA_W-1:0] value);
    int gap, r;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r < 20) gap = $urandom_range(1, 3);
      else if (r < 24) gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_row_index <= row;
    in_col_index <= col;
    in_element_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // let every expected result arrive, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the checker log the last accepted item first
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(logic [DIM_W-1:0] xr, logic [DIM_W-1:0] xc, logic [DIM_W-1:0] yr,
                           logic [DIM_W-1:0] yc, logic xt, logic yt, logic [DATA_W-1:0] a);
    write_reg(CFG_X_ROWS, DATA_W'(xr));
    write_reg(CFG_X_COLS, DATA_W'(xc));
    write_reg(CFG_Y_ROWS, DATA_W'(yr));
    write_reg(CFG_Y_COLS, DATA_W'(yc));
    write_reg(CFG_X_TRANS, DATA_W'(xt));
    write_reg(CFG_Y_TRANS, DATA_W'(yt));
    write_reg(CFG_ALPHA, a);
  endtask

  // stimulus and verdict
  initial begin
    int r, n_items;
    logic [DIM_W-1:0] xr, xc, yr, yc;
    logic xt, yt;
    logic [DATA_W-1:0] a;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every entry so no start ever reads an unwritten one
    for (int i = 0; i < 64; i++) begin
      send_item(REQ_WR_X, IDX_W'(i / 8), IDX_W'(i % 8), pick_value());
      send_item(REQ_WR_Y, IDX_W'(i / 8), IDX_W'(i % 8), pick_value());
    end
    send_item(REQ_START, 0, 0, 0);
    wait_idle();

    // directed: extremes of size, alpha, transposes, mismatch, clamps
    send_item(REQ_WR_X, 0, 0, 32'h7FFF_FFFF);
    send_item(REQ_WR_Y, 0, 0, 32'h7FFF_FFFF);
    send_item(REQ_WR_X, 7, 7, 32'h8000_0000);
    send_item(REQ_WR_Y, 7, 7, 32'h8000_0000);
    wait_idle();
    set_shape(8, 8, 8, 8, 0, 0, 32'h7FFF_FFFF);
    send_item(REQ_START, 0, 0, 0);
    wait_idle();
    set_shape(8, 8, 8, 8, 1, 1, 32'h8000_0000);
    send_item(REQ_START, 7, 7, 32'hFFFF_FFFF);
    wait_idle();
    set_shape(3, 5, 2, 4, 0, 0, 32'h0001_0000);
    send_item(REQ_START, 0, 0, 0);
    wait_idle();
    set_shape(5, 3, 4, 5, 1, 1, 32'h0000_0000);
    send_item(REQ_START, 0, 0, 0);
    wait_idle();
    set_shape(0, 15, 15, 0, 1, 0, 32'hFFFF_0000);
    send_item(REQ_NOP, 7, 7, 32'hFFFF_FFFF);
    send_item(REQ_START, 0, 0, 0);
    wait_idle();
    set_shape(15, 0, 0, 15, 0, 1, 32'h0000_8000);
    write_reg(CFG_NONE, 32'hFFFF_FFFF);
    send_item(REQ_START, 0, 0, 0);
    wait_idle();
    set_shape(1, 1, 1, 1, 0, 0, 32'h0001_0000);
    send_item(REQ_START, 0, 0, 0);
    wait_idle();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      xr = pick_dim(); xc = pick_dim(); yr = pick_dim(); yc = pick_dim();
      xt = 1'($urandom_range(0, 1)); yt = 1'($urandom_range(0, 1));
      // mostly agreeing inner dimensions
      if ($urandom_range(0, 3) != 0) begin
        if (xt == yt) begin
          if (xt) yc = xr; else yr = xc;
        end else begin
          if (xt) yr = xr; else yc = xc;
        end
      end
      r = $urandom_range(0, 5);
      a = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF : pick_value();
      set_shape(xr, xc, yr, yc, xt, yt, a);
      gaps_on = (ph % 4 != 1);
      if (ph == 3) hold_req = 1'b1;
      n_items = 30;
      for (int it = 0; it < n_items; it++) begin
        r = $urandom_range(0, 99);
        if (r < 15 || (ph == 3 && it < 6))
          send_item(REQ_START, IDX_W'($urandom), IDX_W'($urandom), $urandom);
        else if (r < 18)
          send_item(REQ_NOP, IDX_W'($urandom), IDX_W'($urandom), $urandom);
        else if (r < 59)
          send_item(REQ_WR_X, IDX_W'($urandom), IDX_W'($urandom), pick_value());
        else
          send_item(REQ_WR_Y, IDX_W'($urandom), IDX_W'($urandom), pick_value());
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
